/* rtl/core/slt_pkg.sv */
// ============================================================================
// slt_pkg: shared types and constants for the shell line tokenizer
// Item types for both channels, character codes, scan modes and queue sizing.
// ============================================================================
`default_nettype none

package slt_pkg;

    // Character codes that steer the scan.
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    // Scan modes.
    localparam logic [1:0] MODE_BETWEEN = 2'd0;
    localparam logic [1:0] MODE_WORD    = 2'd1;
    localparam logic [1:0] MODE_QUOTE   = 2'd2;
    localparam logic [1:0] MODE_REDIR   = 2'd3;

    // Result queue: room for two results per item plus slack for one read.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // One input item.
    typedef struct packed {
        logic [7:0] ch;
        logic       line_last;
    } slt_in_t;

    // One result item.
    typedef struct packed {
        logic [7:0] token_byte;
        logic       has_byte;
        logic       token_start;
        logic       token_end;
        logic       line_end;
    } slt_out_t;

    // Results produced by one accepted item, handed to the queue.
    typedef struct packed {
        logic [1:0] count;
        slt_out_t   first;
        slt_out_t   second;
    } slt_push_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_redir(input logic [7:0] c);
        return (c == CH_LT) || (c == CH_GT);
    endfunction

    function automatic logic opens_quote(input logic [7:0] c);
        return (c == CH_SQUOTE) || (c == CH_DQUOTE);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/slt_scan.sv */
// ============================================================================
// slt_scan: tokenizer scan state and per-item step
// Holds the scan mode and the pending token byte, and on every accepted item
// works out the zero to two results that the item releases.
// ============================================================================
`default_nettype none

module slt_scan (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire slt_pkg::slt_in_t  cmd,
    output slt_pkg::slt_push_t     push
);
    import slt_pkg::*;

    logic [1:0] mode_reg, mode_next;
    logic       qdbl_reg, qdbl_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;
    logic       held_start_reg, held_start_next;

    logic       cont;
    logic [7:0] c;
    logic [7:0] close_ch;
    slt_out_t   res_held;
    slt_out_t   res_last;
    logic       give_last;

    assign c        = cmd.ch;
    assign close_ch = qdbl_reg ? CH_DQUOTE : CH_SQUOTE;

    // Step of the scan for the current byte.
    always_comb
    begin
        cont            = 1'b0;
        mode_next       = mode_reg;
        qdbl_next       = qdbl_reg;
        held_byte_next  = held_byte_reg;
        held_start_next = held_start_reg;
        held_valid_next = 1'b0;

        // Does the byte continue the current token?
        unique case (mode_reg)
            MODE_WORD:
            begin
                if (!is_blank(c) && (c != CH_PIPE) && !is_redir(c))
                begin
                    cont = 1'b1;
                    if (opens_quote(c))
                    begin
                        mode_next = MODE_QUOTE;
                        qdbl_next = (c == CH_DQUOTE);
                    end
                end
            end
            MODE_QUOTE:
            begin
                cont = 1'b1;
                if (c == close_ch)
                begin
                    mode_next = MODE_WORD;
                end
            end
            MODE_REDIR:
            begin
                if (is_redir(c))
                begin
                    cont      = 1'b1;
                    mode_next = MODE_BETWEEN;
                end
            end
            default:
            begin
                cont = 1'b0;
            end
        endcase

        // The byte becomes the new pending byte unless it is a blank.
        if (cont)
        begin
            held_byte_next  = c;
            held_start_next = 1'b0;
            held_valid_next = 1'b1;
        end
        else if (is_blank(c))
        begin
            mode_next = MODE_BETWEEN;
        end
        else
        begin
            held_byte_next  = c;
            held_start_next = 1'b1;
            held_valid_next = 1'b1;
            if (c == CH_PIPE)
            begin
                mode_next = MODE_BETWEEN;
            end
            else if (is_redir(c))
            begin
                mode_next = MODE_REDIR;
            end
            else if (opens_quote(c))
            begin
                mode_next = MODE_QUOTE;
                qdbl_next = (c == CH_DQUOTE);
            end
            else
            begin
                mode_next = MODE_WORD;
            end
        end
    end

    // Results: the previously pending byte, then the line-end result.
    always_comb
    begin
        res_held.token_byte  = held_byte_reg;
        res_held.has_byte    = 1'b1;
        res_held.token_start = held_start_reg;
        res_held.token_end   = !cont;
        res_held.line_end    = cmd.line_last && !held_valid_next;

        if (held_valid_next)
        begin
            res_last.token_byte  = held_byte_next;
            res_last.has_byte    = 1'b1;
            res_last.token_start = held_start_next;
            res_last.token_end   = 1'b1;
        end
        else
        begin
            res_last.token_byte  = 8'h00;
            res_last.has_byte    = 1'b0;
            res_last.token_start = 1'b0;
            res_last.token_end   = 1'b0;
        end
        res_last.line_end = 1'b1;

        give_last   = cmd.line_last && (held_valid_next || !held_valid_reg);
        push.first  = held_valid_reg ? res_held : res_last;
        push.second = res_last;
        push.count  = 2'(held_valid_reg) + 2'(give_last);
    end

    // Scan state; a line's final byte returns it to the reset state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_BETWEEN;
            qdbl_reg       <= 1'b0;
            held_byte_reg  <= 8'h00;
            held_valid_reg <= 1'b0;
            held_start_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (cmd.line_last)
            begin
                mode_reg       <= MODE_BETWEEN;
                qdbl_reg       <= 1'b0;
                held_byte_reg  <= 8'h00;
                held_valid_reg <= 1'b0;
                held_start_reg <= 1'b0;
            end
            else
            begin
                mode_reg       <= mode_next;
                qdbl_reg       <= qdbl_next;
                held_byte_reg  <= held_byte_next;
                held_valid_reg <= held_valid_next;
                held_start_reg <= held_start_next;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/slt_outq.sv */
// ============================================================================
// slt_outq: result queue of the shell line tokenizer
// Register queue: up to two in per cycle given room; one out unless stalled.
// ============================================================================
`default_nettype none

module slt_outq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_en,
    input  wire slt_pkg::slt_push_t push,
    output logic                    room,
    output logic                    tok_valid,
    input  wire logic               tok_stall,
    output slt_pkg::slt_out_t       tok
);
    import slt_pkg::*;

    slt_out_t           mem [OQ_DEPTH];
    logic [OQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OQ_AW-1:0]   rd_ptr_reg;
    logic [OQ_CW-1:0]   count_reg, count_next;
    logic [1:0]         n_wr;
    logic               pop;

    assign n_wr      = push_en ? push.count : 2'd0;
    assign tok_valid = (count_reg != '0);
    assign tok       = mem[rd_ptr_reg];
    assign pop       = tok_valid && !tok_stall;

    // Accept an item only while two free entries are certain.
    assign room = (count_reg <= OQ_CW'(OQ_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + OQ_AW'(n_wr);
    assign count_next  = count_reg + OQ_CW'(n_wr) - OQ_CW'(pop);

    // Storage writes.
    always_ff @(posedge clk)
    begin
        if (n_wr != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (n_wr == 2'd2)
        begin
            mem[wr_ptr_reg + OQ_AW'(1)] <= push.second;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OQ_AW'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/shell_line_tokenizer_core.sv */
// ============================================================================
// shell_line_tokenizer_core: streaming shell command-line tokenizer
// Marks tokens in a byte stream and passes token bytes on with flags.
// ============================================================================
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd): one byte of a command line per
//   item, with line_last set on the final byte of the line.
//   tok channel (tok_valid / tok_stall / tok): token bytes with start, end and
//   line-end flags, or a bare line-end marker when a line has no byte left.
//   Each byte is held back by one item so its end flag is known; the final
//   byte of a line releases up to two results at once.
//   Results of an item enter the result queue when it is accepted and are
//   offered on tok behind any earlier results. One item is taken per cycle
//   while cmd_stall is low, with a combinational scan step; the four-entry
//   result queue drains one result per cycle while tok_stall is low.
//   cmd_stall rises while the queue holds three or more results, so a stalled
//   receiver backs up into the sender. A stalled result holds.
//   Reset clears the scan state and empties the queue; no item is lost on
//   the tok side while stalled.
// ============================================================================
`default_nettype none

module shell_line_tokenizer_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire slt_pkg::slt_in_t  cmd,
    output logic                   tok_valid,
    input  wire logic              tok_stall,
    output slt_pkg::slt_out_t      tok
);
    import slt_pkg::*;

    slt_push_t push;
    logic      room;
    logic      accept;

    assign cmd_stall = !room;
    assign accept    = cmd_valid && room;

    // Scan step and pending byte.
    slt_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cmd    (cmd),
        .push   (push)
    );

    // Result queue toward the receiver.
    slt_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (accept),
        .push      (push),
        .room      (room),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok       (tok)
    );

endmodule

`default_nettype wire

/* rtl/core/slt_checker.sv */
// ============================================================================
// slt_checker: port-level checks for the shell line tokenizer
// Watches the channels of the top level and is bound to it below.
// ============================================================================
`default_nettype none

module slt_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    input  wire logic              cmd_stall,
    input  wire slt_pkg::slt_in_t  cmd,
    input  wire logic              tok_valid,
    input  wire logic              tok_stall,
    input  wire slt_pkg::slt_out_t tok
);

    // A stalled input item stays offered and unchanged.
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
        else $error("stalled input item changed or vanished");

    // A stalled result stays offered and unchanged.
    a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_stall |=> tok_valid && $stable(tok))
        else $error("stalled result item changed or vanished");

    // A bare marker carries nothing but the line end.
    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok.has_byte |->
            tok.line_end && !tok.token_start && !tok.token_end)
        else $error("bare marker item carries token flags");

    // The last byte of a line always closes its token.
    a_line_closes: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok.line_end && tok.has_byte |-> tok.token_end)
        else $error("line ends inside an open token");

    // The block does not produce results on its own out of reset.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tok_valid) |-> $past(cmd_valid && !cmd_stall))
        else $error("result item appeared without an accepted input item");

endmodule

bind shell_line_tokenizer_core slt_checker u_slt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok       (tok)
);

`default_nettype wire

/* tb/sv/slt_token_checker.sv */
`timescale 1ns / 100ps
// ============================================================================
// slt_token_checker: scoreboard for the shell line tokenizer
// Watches both channels of the tokenizer, predicts the token results of every
// accepted command byte, and compares each delivered result with the oldest
// prediction. Counts failures and exposes them to the test top.
// ============================================================================

module slt_token_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_stall,
    input  slt_pkg::slt_in_t  cmd,
    input  logic              tok_valid,
    input  logic              tok_stall,
    input  slt_pkg::slt_out_t tok,
    output int                fail_count,
    output int                pending,
    output int                checked
);
    import slt_pkg::*;

    // Predicted scanner state.
    logic [7:0] held_byte;
    logic       held_valid;
    logic       held_start;
    logic [1:0] scan_mode;
    logic       quote_dq;

    // Token results still owed by the block, oldest first.
    slt_out_t expected_tokens[$];
    int       n_fail;
    int       n_checked;

    function automatic slt_out_t make_result(input logic [7:0] b, input logic has,
                                             input logic st, input logic en,
                                             input logic le);
        slt_out_t r;
        r.token_byte  = b;
        r.has_byte    = has;
        r.token_start = st;
        r.token_end   = en;
        r.line_end    = le;
        return r;
    endfunction

    task automatic clear_scan();
        held_byte  = '0;
        held_valid = 1'b0;
        held_start = 1'b0;
        scan_mode  = MODE_BETWEEN;
        quote_dq   = 1'b0;
    endtask

    // Advance the predicted scanner by one byte and queue the results it releases.
    task automatic tokenize_byte(input slt_in_t item);
        logic [7:0] c;
        logic       cont;
        slt_out_t   step_out[2];
        int         n;
        c    = item.ch;
        cont = 1'b0;
        n    = 0;

        // Decide whether the byte continues the current token.
        case (scan_mode)
            MODE_WORD:
                if (!(c inside {CH_SPACE, CH_TAB, CH_PIPE, CH_LT, CH_GT}))
                begin
                    cont = 1'b1;
                    if (c inside {CH_SQUOTE, CH_DQUOTE})
                    begin
                        scan_mode = MODE_QUOTE;
                        quote_dq  = (c == CH_DQUOTE);
                    end
                end
            MODE_QUOTE:
            begin
                cont = 1'b1;
                if (c == (quote_dq ? CH_DQUOTE : CH_SQUOTE))
                    scan_mode = MODE_WORD;
            end
            MODE_REDIR:
                if (c inside {CH_LT, CH_GT})
                begin
                    cont      = 1'b1;
                    scan_mode = MODE_BETWEEN;
                end
            default: ;
        endcase

        // The held byte now knows whether it ends its token.
        if (held_valid)
        begin
            step_out[n] = make_result(held_byte, 1'b1, held_start, !cont, 1'b0);
            n++;
            held_valid = 1'b0;
        end

        // Hold the new byte, or drop it as a blank.
        if (cont)
        begin
            held_byte  = c;
            held_start = 1'b0;
            held_valid = 1'b1;
        end
        else if (c inside {CH_SPACE, CH_TAB})
            scan_mode = MODE_BETWEEN;
        else
        begin
            held_byte  = c;
            held_start = 1'b1;
            held_valid = 1'b1;
            if (c == CH_PIPE)
                scan_mode = MODE_BETWEEN;
            else if (c inside {CH_LT, CH_GT})
                scan_mode = MODE_REDIR;
            else if (c inside {CH_SQUOTE, CH_DQUOTE})
            begin
                scan_mode = MODE_QUOTE;
                quote_dq  = (c == CH_DQUOTE);
            end
            else
                scan_mode = MODE_WORD;
        end

        // Line end flushes the held byte, marks the last result, or adds a marker.
        if (item.line_last)
        begin
            if (held_valid)
            begin
                step_out[n] = make_result(held_byte, 1'b1, held_start, 1'b1, 1'b1);
                n++;
            end
            else if (n > 0)
                step_out[n-1].line_end = 1'b1;
            else
            begin
                step_out[n] = make_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
                n++;
            end
            clear_scan();
        end

        for (int i = 0; i < n; i++)
            expected_tokens.push_back(step_out[i]);
    endtask

    // Compare delivered results first, then predict from the accepted byte.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scan();
            expected_tokens.delete();
            n_fail     = 0;
            n_checked  = 0;
            fail_count <= 0;
            pending    <= 0;
            checked    <= 0;
        end
        else
        begin
            if (tok_valid && !tok_stall)
            begin
                if (expected_tokens.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("ERROR: unexpected result byte=%h has=%b st=%b en=%b le=%b",
                                 tok.token_byte, tok.has_byte, tok.token_start,
                                 tok.token_end, tok.line_end);
                end
                else
                begin
                    slt_out_t want;
                    want = expected_tokens.pop_front();
                    n_checked++;
                    if (tok.token_byte !== want.token_byte || tok.has_byte !== want.has_byte
                        || tok.token_start !== want.token_start
                        || tok.token_end !== want.token_end
                        || tok.line_end !== want.line_end)
                    begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display("ERROR: result %0d expected %h/%b%b%b%b got %h/%b%b%b%b",
                                     n_checked, want.token_byte, want.has_byte,
                                     want.token_start, want.token_end, want.line_end,
                                     tok.token_byte, tok.has_byte, tok.token_start,
                                     tok.token_end, tok.line_end);
                    end
                end
            end

            if (cmd_valid && !cmd_stall)
                tokenize_byte(cmd);

            fail_count <= n_fail;
            pending    <= expected_tokens.size();
            checked    <= n_checked;
        end
    end

endmodule

/* tb/sv/shell_line_tokenizer_core_test.sv */
`timescale 1ns / 100ps
// ============================================================================
// shell_line_tokenizer_core_test: regression for the shell line tokenizer
// Feeds directed and random command lines through the tokenizer with random
// gaps on both sides, long receiver hold-offs and drain pauses, while the
// checker predicts and compares every token result.
// ============================================================================

module shell_line_tokenizer_core_test;
    import slt_pkg::*;

    localparam int HOLD_CYCLES = 80;
    localparam int QUIET_LIMIT = 2000;
    localparam int ITEM_TARGET = 1900;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_stall;
    slt_in_t  cmd       = '0;
    logic     tok_valid;
    logic     tok_stall = 1'b0;
    slt_out_t tok;

    int fail_count;
    int pending;
    int checked;

    // Receiver hold-off requests, served by the receiver process.
    int holds_asked  = 0;
    int holds_served = 0;
    int hold_left    = 0;
    logic calm       = 1'b0;

    int bytes_sent = 0;
    int lines_sent = 0;

    shell_line_tokenizer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok       (tok)
    );

    slt_token_checker u_scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .tok        (tok),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (!rst_n)
            tok_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            tok_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (holds_served != holds_asked)
        begin
            tok_stall    <= 1'b1;
            hold_left    <= HOLD_CYCLES - 1;
            holds_served <= holds_served + 1;
        end
        else
            tok_stall <= !calm && ($urandom_range(0, 99) < 12);
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (cmd_valid && !cmd_stall) || (tok_valid && !tok_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one byte, with random gaps before it, and wait for acceptance.
    task automatic send_byte(input logic [7:0] c, input logic last);
        logic quiet_phase;
        quiet_phase = (bytes_sent >= 500 && bytes_sent < 800);
        calm <= quiet_phase;
        while (!quiet_phase && $urandom_range(0, 99) < 12)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd       <= '{ch: c, line_last: last};
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        bytes_sent++;
    endtask

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
        lines_sent++;
    endtask

    // Sender pause until every predicted result has been delivered.
    task automatic drain_tokens();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Mostly shell-meaningful bytes, with some arbitrary ones mixed in.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return CH_SPACE;
        if (r < 14) return CH_TAB;
        if (r < 20) return CH_PIPE;
        if (r < 26) return CH_LT;
        if (r < 32) return CH_GT;
        if (r < 38) return CH_SQUOTE;
        if (r < 44) return CH_DQUOTE;
        if (r < 56) return 8'($urandom_range(0, 255));
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    initial
    begin
        int len;
        logic noise;
        logic [7:0] c;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines: pipe, redirect pair, unclosed quote, quoted separators,
        // trailing blank, blank-only line, extreme byte values, leading quote.
        send_line("a|b");
        send_line("<<>x");
        send_line("w'a b");
        send_line("x\"|\"y ");
        send_line("\t");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        lines_sent++;
        send_line("'q'");
        drain_tokens();

        // Long receiver hold-off while the sender keeps offering bytes.
        holds_asked <= holds_asked + 1;

        while (bytes_sent < ITEM_TARGET)
        begin
            if (lines_sent == 120)
                drain_tokens();
            if (lines_sent == 160)
                holds_asked <= holds_asked + 1;
            noise = ($urandom_range(0, 9) == 0);
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 60)
                                                : $urandom_range(1, 16);
            for (int i = 0; i < len; i++)
            begin
                c = noise ? 8'($urandom_range(0, 255)) : pick_byte();
                send_byte(c, i == len - 1);
            end
            lines_sent++;
        end

        drain_tokens();
        repeat (8) @(posedge clk);

        if (pending != 0)
            $display("ERROR: %0d predicted results never arrived", pending);
        $display("Summary: %0d bytes in %0d lines sent, %0d token results checked.",
                 bytes_sent, lines_sent, checked);
        $display("Lines mixed words, pipes, redirects, quoted runs and blank lines.");
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
